/* src/x86alu_pkg.sv */
// Shared opcodes, width codes, controller/datapath interface types and helpers.
package x86alu_pkg;

	localparam logic [3:0] OP_ADD        = 4'd0;
	localparam logic [3:0] OP_SUB        = 4'd1;
	localparam logic [3:0] OP_CMP        = 4'd2;
	localparam logic [3:0] OP_ADC        = 4'd3;
	localparam logic [3:0] OP_SBB        = 4'd4;
	localparam logic [3:0] OP_DEC        = 4'd5;
	localparam logic [3:0] OP_MUL        = 4'd6;
	localparam logic [3:0] OP_IMUL1      = 4'd7;
	localparam logic [3:0] OP_IMUL_TRUNC = 4'd8;
	localparam logic [3:0] OP_DIV        = 4'd9;
	localparam logic [3:0] OP_IDIV       = 4'd10;

	localparam logic [1:0] WC_BYTE = 2'd0;
	localparam logic [1:0] WC_WORD = 2'd1;

	localparam int IN_BITS  = 136;
	localparam int OUT_BITS = 104;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_go;
		logic last_step;
		logic out_free;
	} dp_status_t;

	// Mask of the operand width; width code three acts as doubleword.
	function automatic logic [31:0] width_mask(input logic [1:0] wc);
		case (wc)
			WC_BYTE: width_mask = 32'h0000_00ff;
			WC_WORD: width_mask = 32'h0000_ffff;
			default: width_mask = 32'hffff_ffff;
		endcase
	endfunction

	// Sign bit of a value at the operand width.
	function automatic logic width_msb(input logic [31:0] v, input logic [1:0] wc);
		case (wc)
			WC_BYTE: width_msb = v[7];
			WC_WORD: width_msb = v[15];
			default: width_msb = v[31];
		endcase
	endfunction

	// Sign-extend a value of the operand width to 33 bits.
	function automatic logic [32:0] sext33(input logic [31:0] v, input logic [1:0] wc);
		case (wc)
			WC_BYTE: sext33 = {{25{v[7]}}, v[7:0]};
			WC_WORD: sext33 = {{17{v[15]}}, v[15:0]};
			default: sext33 = {v[31], v};
		endcase
	endfunction

endpackage

/* src/x86_integer_alu_with_flags_top.sv */
// Sequence: the input beat is loaded in idle and the operands are prepared; a good divide then runs
// its restoring steps, and the finish state registers the result beat. Other operations go straight to finish.
// One instruction in flight; the next input beat is taken only once the controller is back in idle
// (a good divide runs one restoring step per quotient bit).
// A new beat is taken while a result waits; a stalled result holds the next one at finish.
// Reset (arst_n low) clears CF, OF, SF, ZF, the controller and the output valid.
module x86_integer_alu_with_flags_top
	import x86alu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// opcode, width_code, dest_value, src_value, acc_low, acc_high
	input  logic [IN_BITS-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// dest_result, dest_write, acc_low_result, acc_high_result, acc_write,
	// carry_flag, overflow_flag, sign_flag, zero_flag, divide_error
	output logic [OUT_BITS-1:0] m_tdata
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_fire;

	assign in_fire = s_tvalid && s_tready;

	x86alu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.status   (status),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	x86alu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.status    (status),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

/* src/x86alu_ctrl.sv */
// Controller state machine: accept, prepare, divide steps, finish.
module x86alu_ctrl
	import x86alu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  dp_status_t status,
	output logic       in_ready,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_STEP, ST_FIN} state_t;

	state_t state_q;

	// Advance state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_PREP;
				ST_PREP: state_q <= status.div_go ? ST_STEP : ST_FIN;
				ST_STEP: if (status.last_step) state_q <= ST_FIN;
				ST_FIN:  if (status.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Decode commands.
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.load   = in_fire;
		cmd.prep   = (state_q == ST_PREP);
		cmd.step   = (state_q == ST_STEP);
		cmd.finish = (state_q == ST_FIN) && status.out_free;
	end

endmodule

/* src/x86alu_dp.sv */
// Datapath: operand registers, adder, multiplier, restoring divider, flags, result register.
module x86alu_dp
	import x86alu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [IN_BITS-1:0]  in_data,
	input  logic                out_ready,
	output dp_status_t          status,
	output logic                out_valid,
	output logic [OUT_BITS-1:0] out_data
);

	logic [3:0]  op_q;
	logic [1:0]  wc_q;
	logic [31:0] a_q, b_q, eax_q, edx_q;
	logic [31:0] rem_q, lo_q, quo_q, dm_q;
	logic [63:0] prod_q;
	logic        dneg_q, sneg_q, err_q;
	logic [5:0]  cnt_q;
	logic        cf_q, of_q, sf_q, zf_q;
	logic        out_valid_q;
	logic [OUT_BITS-1:0] out_q;

	// Prepare: divide magnitudes and alignment, multiplier operands.
	logic        is_div, sdiv, dneg, sneg, div_err0;
	logic [31:0] m, dm, hi, lo;
	logic [63:0] dvd, dvd_mag, m2;
	logic [32:0] mx, my;
	logic [65:0] prod;
	always_comb begin
		m    = width_mask(wc_q);
		is_div = (op_q == OP_DIV) || (op_q == OP_IDIV);
		sdiv = (op_q == OP_IDIV);
		case (wc_q)
			WC_BYTE: begin
				dvd  = {48'b0, eax_q[15:0]};
				m2   = 64'h0000_0000_0000_ffff;
				dneg = sdiv && eax_q[15];
			end
			WC_WORD: begin
				dvd  = {32'b0, edx_q[15:0], eax_q[15:0]};
				m2   = 64'h0000_0000_ffff_ffff;
				dneg = sdiv && edx_q[15];
			end
			default: begin
				dvd  = {edx_q, eax_q};
				m2   = 64'hffff_ffff_ffff_ffff;
				dneg = sdiv && edx_q[31];
			end
		endcase
		dvd_mag = dneg ? ((~dvd + 64'd1) & m2) : dvd;
		sneg = sdiv && width_msb(a_q, wc_q);
		dm   = sneg ? ((~a_q + 32'd1) & m) : a_q;
		case (wc_q)
			WC_BYTE: begin
				hi = {24'b0, dvd_mag[15:8]};
				lo = {dvd_mag[7:0], 24'b0};
			end
			WC_WORD: begin
				hi = {16'b0, dvd_mag[31:16]};
				lo = {dvd_mag[15:0], 16'b0};
			end
			default: begin
				hi = dvd_mag[63:32];
				lo = dvd_mag[31:0];
			end
		endcase
		div_err0 = (dm == 32'd0) || (hi >= dm);
		case (op_q)
			OP_MUL: begin
				mx = {1'b0, eax_q & m};
				my = {1'b0, a_q};
			end
			OP_IMUL1: begin
				mx = sext33(eax_q & m, wc_q);
				my = sext33(a_q, wc_q);
			end
			default: begin
				mx = sext33(a_q, wc_q);
				my = sext33(b_q, wc_q);
			end
		endcase
		prod = $signed(mx) * $signed(my);
	end

	// One restoring divide step.
	logic [32:0] trial;
	logic        ge;
	logic [32:0] diff;
	always_comb begin
		trial = {rem_q, lo_q[31]};
		ge    = trial >= {1'b0, dm_q};
		diff  = trial - {1'b0, dm_q};
	end

	// Finish: results and flags.
	logic [31:0] fm, bb, r, dres, lres, hres, half, qv, rv;
	logic [32:0] sum, dif;
	logic        c, ncf, nof, nsf, nzf, dw, aw, err, qneg, iovf, upd;
	always_comb begin
		fm   = width_mask(wc_q);
		c    = ((op_q == OP_ADC) || (op_q == OP_SBB)) ? cf_q : 1'b0;
		bb   = (op_q == OP_DEC) ? 32'd1 : b_q;
		sum  = {1'b0, a_q} + {1'b0, bb} + {32'b0, c};
		dif  = {1'b0, a_q} - {1'b0, bb} - {32'b0, c};
		r    = 32'd0;
		dres = 32'd0;
		lres = 32'd0;
		hres = 32'd0;
		dw   = 1'b0;
		aw   = 1'b0;
		err  = 1'b0;
		upd  = 1'b0;
		ncf  = cf_q;
		nof  = of_q;
		nsf  = sf_q;
		nzf  = zf_q;
		qneg = dneg_q ^ sneg_q;
		case (wc_q)
			WC_BYTE: half = 32'h0000_0080;
			WC_WORD: half = 32'h0000_8000;
			default: half = 32'h8000_0000;
		endcase
		iovf = qneg ? (quo_q > half) : (quo_q >= half);
		qv   = (qneg ? (~quo_q + 32'd1) : quo_q) & fm;
		rv   = (dneg_q ? (~rem_q + 32'd1) : rem_q) & fm;
		case (op_q)
			OP_ADD, OP_ADC: begin
				r   = sum[31:0] & fm;
				upd = 1'b1;
				case (wc_q)
					WC_BYTE: ncf = sum[8];
					WC_WORD: ncf = sum[16];
					default: ncf = sum[32];
				endcase
				nof = width_msb(~(a_q ^ bb) & (a_q ^ r), wc_q);
			end
			OP_SUB, OP_CMP, OP_SBB, OP_DEC: begin
				r   = dif[31:0] & fm;
				upd = 1'b1;
				if (op_q != OP_DEC) ncf = dif[32];
				nof = width_msb((a_q ^ bb) & (a_q ^ r), wc_q);
			end
			OP_MUL, OP_IMUL1: begin
				aw = 1'b1;
				case (wc_q)
					WC_BYTE: begin
						lres = {eax_q[31:16], prod_q[15:0]};
						hres = edx_q;
					end
					WC_WORD: begin
						lres = {eax_q[31:16], prod_q[15:0]};
						hres = {edx_q[31:16], prod_q[31:16]};
					end
					default: begin
						lres = prod_q[31:0];
						hres = prod_q[63:32];
					end
				endcase
			end
			OP_IMUL_TRUNC: begin
				dres = prod_q[31:0] & fm;
				dw   = 1'b1;
			end
			OP_DIV, OP_IDIV: begin
				err = err_q || ((op_q == OP_IDIV) && iovf);
				if (!err) begin
					aw = 1'b1;
					case (wc_q)
						WC_BYTE: begin
							lres = {eax_q[31:16], rv[7:0], qv[7:0]};
							hres = edx_q;
						end
						WC_WORD: begin
							lres = {eax_q[31:16], qv[15:0]};
							hres = {edx_q[31:16], rv[15:0]};
						end
						default: begin
							lres = qv;
							hres = rv;
						end
					endcase
				end
			end
			default: begin
				upd = 1'b0;
			end
		endcase
		if (upd) begin
			nsf = width_msb(r, wc_q);
			nzf = (r == 32'd0);
			if (op_q != OP_CMP) begin
				dres = r;
				dw   = 1'b1;
			end
		end
	end

	// Hold operands, divider state, product and the result beat.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_data[3:0];
			wc_q  <= in_data[5:4];
			a_q   <= in_data[37:6] & width_mask(in_data[5:4]);
			b_q   <= in_data[69:38] & width_mask(in_data[5:4]);
			eax_q <= in_data[101:70];
			edx_q <= in_data[133:102];
		end
		if (cmd.prep) begin
			rem_q  <= hi;
			lo_q   <= lo;
			dm_q   <= dm;
			quo_q  <= 32'd0;
			dneg_q <= dneg;
			sneg_q <= sneg;
			err_q  <= is_div && div_err0;
			prod_q <= prod[63:0];
			case (wc_q)
				WC_BYTE: cnt_q <= 6'd8;
				WC_WORD: cnt_q <= 6'd16;
				default: cnt_q <= 6'd32;
			endcase
		end
		if (cmd.step) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
			cnt_q <= cnt_q - 6'd1;
		end
		if (cmd.finish) begin
			out_q <= {1'b0, err, nzf, nsf, nof, ncf, aw, hres, lres, dw, dres};
		end
	end

	// Update flags and output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_q        <= 1'b0;
			of_q        <= 1'b0;
			sf_q        <= 1'b0;
			zf_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				cf_q        <= ncf;
				of_q        <= nof;
				sf_q        <= nsf;
				zf_q        <= nzf;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.div_go    = is_div && !div_err0;
	assign status.last_step = (cnt_q == 6'd1);
	assign status.out_free  = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign out_data         = out_q;

endmodule
